// ===== hdl/brd_pkg.sv =====
// Shared types and constants of the bitmap rectangle draw engine.
package brd_pkg;

   // Width of row and column sums, which reach start + extent of up to 94.
   localparam int SUM_W = 7;

   typedef enum logic [2:0] {
      OP_FILL    = 3'd0,
      OP_OUTLINE = 3'd1,
      OP_VLINE   = 3'd2,
      OP_HLINE   = 3'd3,
      OP_CLEAR   = 3'd4,
      OP_READ    = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

// ===== hdl/brd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/brd_mask.sv =====
// Column masks of one command: full span and outline side columns, clipped.
module brd_mask #(
   parameter int FRAME_SIZE = 32
) (
   input  brd_pkg::op_type        operation,
   input  logic [4:0]             start_column,
   input  logic [5:0]             width,
   input  logic [5:0]             length,
   output logic [FRAME_SIZE-1:0]  full_mask,
   output logic [FRAME_SIZE-1:0]  side_mask
);
   import brd_pkg::*;

   logic [SUM_W-1:0] first;
   logic [SUM_W-1:0] count;
   logic [SUM_W-1:0] span_end;
   logic [SUM_W-1:0] right_col;

   always_comb begin
      first = SUM_W'(start_column);
      case (operation)
         OP_HLINE: count = SUM_W'(length);
         OP_VLINE: count = SUM_W'(1);
         default:  count = SUM_W'(width);
      endcase
      span_end  = first + count;
      right_col = first + SUM_W'(width) - SUM_W'(1);
   end

   always_comb begin
      for (int c = 0; c < FRAME_SIZE; c++) begin
         full_mask[c] = (SUM_W'(c) >= first) && (SUM_W'(c) < span_end);
         side_mask[c] = (SUM_W'(c) == first) || (SUM_W'(c) == right_col);
      end
   end

endmodule

// ===== hdl/bitmap_rectangle_draw_engine.sv =====
// Top level: command sequencer doing row read-modify-write on the bitmap RAM.
// Flow: a command is accepted in ST_IDLE, its rows are visited in ST_RUN and the result
//   is loaded in ST_DONE; R, the bitmap rows touched after clipping, is 0..FRAME_SIZE (1 for a read).
// A new command is taken only back in ST_IDLE (req_stall is high otherwise); in ST_RUN one row
//   word is read and, for a drawing command, written back per cycle over the RAM's read and write ports.
// Reset: per-row valid flags clear at once, so the bitmap reads as all clear.
module bitmap_rectangle_draw_engine #(
   parameter int FRAME_SIZE = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [4:0] req_start_row,
   input  logic [4:0] req_start_column,
   input  logic [5:0] req_width,
   input  logic [5:0] req_length,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_pixel_value
);
   import brd_pkg::*;

   localparam int AW = $clog2(FRAME_SIZE);
   localparam logic [SUM_W-1:0] FS_W = SUM_W'(FRAME_SIZE);

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [4:0]            row0_ff, row0_in;
   logic [FRAME_SIZE-1:0] full_ff, full_in;
   logic [FRAME_SIZE-1:0] side_ff, side_in;
   logic [SUM_W-1:0]      rows_ff, rows_in;
   logic [SUM_W-1:0]      last_ff, last_in;
   logic [SUM_W-1:0]      rd_i_ff, rd_i_in;
   logic [SUM_W-1:0]      wr_i_ff, wr_i_in;
   logic                  pend_ff, pend_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic                  col_ok_ff, col_ok_in;
   logic [AW-1:0]         col_idx_ff, col_idx_in;
   logic                  pix_ff, pix_in;
   logic [FRAME_SIZE-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_pixel_ff, rsp_pixel_in;

   op_type                req_op;
   logic [FRAME_SIZE-1:0] mask_full;
   logic [FRAME_SIZE-1:0] mask_side;
   logic [SUM_W-1:0]      row_ext;
   logic [SUM_W-1:0]      col_ext;
   logic [SUM_W-1:0]      nrows;
   logic [SUM_W-1:0]      limit;
   logic [SUM_W-1:0]      rd_sum;
   logic [SUM_W-1:0]      wr_sum;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic                  ram_re;
   logic                  ram_we;
   logic [FRAME_SIZE-1:0] ram_rdata;
   logic [FRAME_SIZE-1:0] ram_wdata;
   logic [FRAME_SIZE-1:0] row_mask;
   logic                  edge_row;

   assign req_op = op_type'(req_operation);

   brd_mask #(.FRAME_SIZE(FRAME_SIZE)) u_mask (
      .operation    (req_op),
      .start_column (req_start_column),
      .width        (req_width),
      .length       (req_length),
      .full_mask    (mask_full),
      .side_mask    (mask_side)
   );

   brd_ram #(.WIDTH(FRAME_SIZE), .DEPTH(FRAME_SIZE)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      row_ext = SUM_W'(req_start_row);
      col_ext = SUM_W'(req_start_column);
      unique case (req_op)
         OP_FILL:    nrows = SUM_W'(req_length);
         OP_OUTLINE: nrows = (req_width != 6'd0) ? SUM_W'(req_length) : '0;
         OP_VLINE:   nrows = SUM_W'(req_length);
         OP_HLINE:   nrows = SUM_W'(1);
         OP_READ:    nrows = SUM_W'(1);
         default:    nrows = '0;
      endcase
      limit = (row_ext < FS_W) ? (FS_W - row_ext) : '0;
   end

   assign rd_sum  = SUM_W'(row0_ff) + rd_i_ff;
   assign wr_sum  = SUM_W'(row0_ff) + wr_i_ff;
   assign rd_addr = rd_sum[AW-1:0];
   assign wr_addr = wr_sum[AW-1:0];

   assign edge_row  = (wr_i_ff == '0) || (wr_i_ff == last_ff);
   assign row_mask  = ((op_ff == OP_OUTLINE) && !edge_row) ? side_ff : full_ff;
   assign ram_wdata = (rd_valid_ff ? ram_rdata : '0) | row_mask;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      row0_in      = row0_ff;
      full_in      = full_ff;
      side_in      = side_ff;
      rows_in      = rows_ff;
      last_in      = last_ff;
      rd_i_in      = rd_i_ff;
      wr_i_in      = wr_i_ff;
      pend_in      = pend_ff;
      rd_valid_in  = rd_valid_ff;
      col_ok_in    = col_ok_ff;
      col_idx_in   = col_idx_ff;
      pix_in       = pix_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      ram_re       = 1'b0;
      ram_we       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               row0_in    = req_start_row;
               full_in    = mask_full;
               side_in    = mask_side;
               rows_in    = (nrows < limit) ? nrows : limit;
               last_in    = nrows - SUM_W'(1);
               rd_i_in    = '0;
               wr_i_in    = '0;
               pend_in    = 1'b0;
               col_ok_in  = col_ext < FS_W;
               col_idx_in = col_ext[AW-1:0];
               pix_in     = 1'b0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            pend_in = 1'b0;
            if (rd_i_ff < rows_ff) begin
               ram_re      = 1'b1;
               rd_i_in     = rd_i_ff + SUM_W'(1);
               wr_i_in     = rd_i_ff;
               pend_in     = 1'b1;
               rd_valid_in = valid_ff[rd_addr];
            end
            if (pend_ff) begin
               if (op_ff inside {OP_FILL, OP_OUTLINE, OP_VLINE, OP_HLINE}) begin
                  ram_we            = 1'b1;
                  valid_in[wr_addr] = 1'b1;
               end
               if (op_ff == OP_READ) begin
                  pix_in = rd_valid_ff & col_ok_ff & ram_rdata[col_idx_ff];
               end
            end
            if (op_ff == OP_CLEAR) begin
               valid_in = '0;
            end
            if ((rd_i_ff >= rows_ff) && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = pix_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      row0_ff      <= row0_in;
      full_ff      <= full_in;
      side_ff      <= side_in;
      rows_ff      <= rows_in;
      last_ff      <= last_in;
      rd_i_ff      <= rd_i_in;
      wr_i_ff      <= wr_i_in;
      rd_valid_ff  <= rd_valid_in;
      col_ok_ff    <= col_ok_in;
      col_idx_ff   <= col_idx_in;
      pix_ff       <= pix_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

`ifndef SYNTHESIS
   a_no_rw_same_row: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (wr_addr != rd_addr))
      else $error("row read and written in the same cycle");

   a_clear_drops_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && op_ff == OP_CLEAR) |=> (valid_ff == '0))
      else $error("clear left a row marked valid");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not handed to the result register");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rd_i_ff <= rows_ff))
      else $error("more rows issued than the clipped row count");
`endif

endmodule
